[rtl/core/uudec_pkg.sv]
// uudec_pkg: types and constants shared by the byte string decoder
// no dependencies
`timescale 1ns / 1ps

package uudec_pkg;

	localparam logic [1:0] MODE_UTF8   = 2'd0;
	localparam logic [1:0] MODE_U16_LE = 2'd1;
	localparam logic [1:0] MODE_U16_BE = 2'd2;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MAX   = 8'hDF;
	localparam logic [7:0] LEAD3_MAX   = 8'hEF;
	localparam logic [7:0] SKIP4_MAX   = 8'hF7;
	localparam logic [7:0] SKIP5_MAX   = 8'hFB;
	localparam logic [7:0] SKIP6_MAX   = 8'hFD;
	localparam logic [7:0] LEAD2_MASK  = 8'h1F;
	localparam logic [7:0] LEAD3_MASK  = 8'h0F;
	localparam logic [7:0] CONT_MASK   = 8'h3F;

	typedef enum logic [2:0] {
		KIND_IDLE  = 3'b001,
		KIND_BUILD = 3'b010,
		KIND_SKIP  = 3'b100
	} uudec_kind_t;

	typedef struct packed {
		logic        unit_valid;
		logic [15:0] code_unit;
		logic        string_end;
	} uudec_res_t;

	typedef struct packed {
		logic seq_idle;
		logic halted;
		logic held_valid;
	} uudec_status_t;

endpackage

[rtl/core/uudec_in_stage.sv]
// uudec_in_stage: input register for one byte with its last flag
// depends on nothing beyond the handshake from the decode stage
`timescale 1ns / 1ps

module uudec_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

endmodule

[rtl/core/uudec_core.sv]
// uudec_core: sequence state and decode logic for one byte per cycle while adv is high
// depends on uudec_pkg
`timescale 1ns / 1ps

module uudec_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic [7:0]              byte_s1,
	input  logic                    last_s1,
	input  logic [1:0]              mode_q,
	output uudec_pkg::uudec_res_t    res,
	output logic                    emit,
	output uudec_pkg::uudec_status_t st
);

	import uudec_pkg::*;

	uudec_kind_t kind_q, kind_d;
	logic [2:0]  pending_q, pending_d;
	logic [11:0] partial_q, partial_d;
	logic        halted_q, halted_d;
	logic [7:0]  held_q, held_d;
	logic        held_valid_q, held_valid_d;
	logic        u_vld;
	logic [15:0] u_val;
	logic [15:0] built;

	assign built = {partial_q[9:0], byte_s1[5:0]};

	always_comb begin
		kind_d       = kind_q;
		pending_d    = pending_q;
		partial_d    = partial_q;
		halted_d     = halted_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		u_vld        = 1'b0;
		u_val        = 16'd0;
		if (!halted_q) begin
			unique case (mode_q) inside
				MODE_UTF8: begin
					unique case (kind_q)
						KIND_BUILD: begin
							if (pending_q <= 3'd1) begin
								pending_d = 3'd0;
								partial_d = 12'd0;
								kind_d    = KIND_IDLE;
								u_vld     = 1'b1;
								u_val     = built;
							end else begin
								partial_d = built[11:0];
								pending_d = pending_q - 3'd1;
							end
						end
						KIND_SKIP: begin
							if (pending_q <= 3'd1) begin
								pending_d = 3'd0;
								kind_d    = KIND_IDLE;
							end else begin
								pending_d = pending_q - 3'd1;
							end
						end
						default: begin
							if (byte_s1 < ASCII_LIMIT) begin
								u_vld = 1'b1;
								u_val = {8'd0, byte_s1};
							end else if (byte_s1 <= LEAD2_MAX) begin
								kind_d    = KIND_BUILD;
								partial_d = {4'd0, byte_s1 & LEAD2_MASK};
								pending_d = 3'd1;
							end else if (byte_s1 <= LEAD3_MAX) begin
								kind_d    = KIND_BUILD;
								partial_d = {4'd0, byte_s1 & LEAD3_MASK};
								pending_d = 3'd2;
							end else if (byte_s1 <= SKIP4_MAX) begin
								kind_d    = KIND_SKIP;
								pending_d = 3'd3;
							end else if (byte_s1 <= SKIP5_MAX) begin
								kind_d    = KIND_SKIP;
								pending_d = 3'd4;
							end else if (byte_s1 <= SKIP6_MAX) begin
								kind_d    = KIND_SKIP;
								pending_d = 3'd5;
							end else begin
								halted_d = 1'b1;
							end
						end
					endcase
				end
				MODE_U16_LE, MODE_U16_BE: begin
					if (!held_valid_q) begin
						if (last_s1) begin
							u_vld = 1'b1;
							u_val = (mode_q == MODE_U16_BE) ? {byte_s1, 8'd0}
											: {8'd0, byte_s1};
						end else begin
							held_d       = byte_s1;
							held_valid_d = 1'b1;
						end
					end else begin
						u_vld        = 1'b1;
						u_val        = (mode_q == MODE_U16_BE) ? {held_q, byte_s1}
										: {byte_s1, held_q};
						held_d       = 8'd0;
						held_valid_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		if (last_s1) begin
			kind_d       = KIND_IDLE;
			pending_d    = 3'd0;
			partial_d    = 12'd0;
			halted_d     = 1'b0;
			held_d       = 8'd0;
			held_valid_d = 1'b0;
		end
	end

	assign emit           = u_vld || last_s1;
	assign res.unit_valid = u_vld;
	assign res.code_unit  = u_val;
	assign res.string_end = last_s1;

	assign st.seq_idle   = (kind_q == KIND_IDLE) && (pending_q == 3'd0);
	assign st.halted     = halted_q;
	assign st.held_valid = held_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= KIND_IDLE;
			pending_q    <= 3'd0;
			partial_q    <= 12'd0;
			halted_q     <= 1'b0;
			held_q       <= 8'd0;
			held_valid_q <= 1'b0;
		end else if (adv) begin
			kind_q       <= kind_d;
			pending_q    <= pending_d;
			partial_q    <= partial_d;
			halted_q     <= halted_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
		end
	end

endmodule

[rtl/core/uudec_out_stage.sv]
// uudec_out_stage: result register holding one decoded word until taken
// depends on uudec_pkg
`timescale 1ns / 1ps

module uudec_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  uudec_pkg::uudec_res_t res,
	output logic                 out_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 unit_valid,
	output logic [15:0]          code_unit,
	output logic                 string_end
);

	import uudec_pkg::*;

	uudec_res_t res_s2;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign unit_valid = res_s2.unit_valid;
	assign code_unit  = res_s2.code_unit;
	assign string_end = res_s2.string_end;

endmodule

[rtl/core/utf8_utf16_to_ucs2_decoder.sv]
// utf8_utf16_to_ucs2_decoder: top level, byte string to 16-bit code words
// depends on uudec_pkg, uudec_in_stage, uudec_core, uudec_out_stage
//
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     data_byte, is_last
// out      output     out_valid / out_ready   unit_valid, code_unit, string_end
// cfg      input      cfg_valid / cfg_ready   mode
//
// one byte per cycle unless out_ready stalls; bytes and words are registered
// the input register and the result register decouple the two sides
// a byte that yields no word moves on even while the result register is full
// out_ready low holds the result register and then backs up the input register
// reset clears all sequence state and sets mode to utf-8
`timescale 1ns / 1ps

module utf8_utf16_to_ucs2_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        unit_valid,
	output logic [15:0] code_unit,
	output logic        string_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  mode
);

	import uudec_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic          adv;
	logic          emit;
	logic          out_free;
	logic [1:0]    mode_q;
	uudec_res_t    res;
	uudec_status_t st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF8;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode;
		end
	end

	assign adv = valid_s1 && (!emit || out_free);

	uudec_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.is_last   (is_last),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1)
	);

	uudec_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.mode_q  (mode_q),
		.res     (res),
		.emit    (emit),
		.st      (st)
	);

	uudec_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv && emit),
		.res        (res),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.unit_valid (unit_valid),
		.code_unit  (code_unit),
		.string_end (string_end)
	);

	// end of string leaves no sequence state behind
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st.seq_idle && !st.halted && !st.held_valid)
		else $error("state not cleared after last byte");

	// a word without a unit only comes from the last byte
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unit_valid |-> string_end && (code_unit == 16'd0))
		else $error("empty result not at end of string");

	// a full, stalled result register blocks any byte that has a result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(adv && emit))
		else $error("result register overwritten");

	// halted drops units in every mode
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		st.halted && adv |-> !res.unit_valid)
		else $error("unit produced while halted");

endmodule

[test/testbench.sv]
// testbench: directed and random byte strings through utf8_utf16_to_ucs2_decoder in all modes,
// each word checked against a behavioral predictor kept in a small scoreboard class
// depends on uudec_pkg and the decoder rtl
`timescale 1ns / 1ps

import uudec_pkg::*;

class ucs2_scoreboard;
	logic [1:0]  mode;
	uudec_kind_t kind;
	logic [2:0]  left;
	logic [11:0] partial;
	logic        halted;
	logic [7:0]  held_byte;
	logic        held_valid;
	uudec_res_t  expected_q[$];
	int          mismatches;

	function new();
		mode = MODE_UTF8;
		mismatches = 0;
		clear_string();
	endfunction

	function void clear_string();
		kind = KIND_IDLE;
		left = '0;
		partial = '0;
		halted = 1'b0;
		held_byte = '0;
		held_valid = 1'b0;
	endfunction

	function void set_mode(logic [1:0] m);
		mode = m;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function bit utf8_step(logic [7:0] b, output logic [15:0] unit);
		logic [7:0]  low6;
		logic [15:0] v;
		unit = '0;
		low6 = b & CONT_MASK;
		v = {partial[9:0], low6[5:0]};
		if (kind == KIND_BUILD) begin
			if (left <= 3'd1) begin
				kind = KIND_IDLE;
				left = '0;
				partial = '0;
				unit = v;
				return 1'b1;
			end
			partial = v[11:0];
			left = left - 3'd1;
			return 1'b0;
		end
		if (kind == KIND_SKIP) begin
			if (left <= 3'd1) begin
				kind = KIND_IDLE;
				left = '0;
			end else begin
				left = left - 3'd1;
			end
			return 1'b0;
		end
		if (b < ASCII_LIMIT) begin
			unit = {8'h00, b};
			return 1'b1;
		end
		if (b <= LEAD2_MAX) begin
			kind = KIND_BUILD;
			partial = {4'h0, b & LEAD2_MASK};
			left = 3'd1;
		end else if (b <= LEAD3_MAX) begin
			kind = KIND_BUILD;
			partial = {4'h0, b & LEAD3_MASK};
			left = 3'd2;
		end else if (b <= SKIP4_MAX) begin
			kind = KIND_SKIP;
			left = 3'd3;
		end else if (b <= SKIP5_MAX) begin
			kind = KIND_SKIP;
			left = 3'd4;
		end else if (b <= SKIP6_MAX) begin
			kind = KIND_SKIP;
			left = 3'd5;
		end else begin
			halted = 1'b1;
		end
		return 1'b0;
	endfunction

	function bit utf16_step(logic [7:0] b, logic big, logic last, output logic [15:0] unit);
		unit = '0;
		if (!held_valid) begin
			if (last) begin
				unit = big ? {b, 8'h00} : {8'h00, b};
				return 1'b1;
			end
			held_byte = b;
			held_valid = 1'b1;
			return 1'b0;
		end
		unit = big ? {held_byte, b} : {b, held_byte};
		held_valid = 1'b0;
		held_byte = '0;
		return 1'b1;
	endfunction

	function void note_byte(logic [7:0] b, logic last);
		logic [15:0] unit;
		bit          got;
		uudec_res_t  r;
		unit = '0;
		got = 1'b0;
		if (!halted) begin
			case (mode)
				MODE_UTF8: got = utf8_step(b, unit);
				MODE_U16_LE: got = utf16_step(b, 1'b0, last, unit);
				MODE_U16_BE: got = utf16_step(b, 1'b1, last, unit);
				default: got = 1'b0;
			endcase
		end
		if (last)
			clear_string();
		if (got || last) begin
			r.unit_valid = got;
			r.code_unit = got ? unit : 16'h0000;
			r.string_end = last;
			expected_q.insert(expected_q.size(), r);
		end
	endfunction

	function void check_word(uudec_res_t got);
		uudec_res_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected word: unit_valid %0b code_unit %h string_end %0b",
					$time, got.unit_valid, got.code_unit, got.string_end);
			return;
		end
		want = expected_q.pop_front();
		if (got.unit_valid !== want.unit_valid || got.code_unit !== want.code_unit ||
				got.string_end !== want.string_end) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: word mismatch: expected %0b/%h/%0b, got %0b/%h/%0b", $time,
					want.unit_valid, want.code_unit, want.string_end,
					got.unit_valid, got.code_unit, got.string_end);
		end
	endfunction
endclass

module testbench;
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        is_last;
	logic        out_valid;
	logic        out_ready;
	logic        unit_valid;
	logic [15:0] code_unit;
	logic        string_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  mode;

	ucs2_scoreboard sb;
	bit             calm;
	bit             hold_req;
	int             bytes_sent;
	logic [7:0]     text_q[$];

	utf8_utf16_to_ucs2_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.unit_valid (unit_valid),
		.code_unit  (code_unit),
		.string_end (string_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.mode       (mode)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// words are checked before the byte of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_word({unit_valid, code_unit, string_end});
			if (cfg_valid && cfg_ready)
				sb.set_mode(mode);
			if (in_valid && in_ready)
				sb.note_byte(data_byte, is_last);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("testbench failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver side
	initial begin
		int run;
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= 1'b1;
			run = $urandom_range(1, 12);
			repeat (run) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		mode <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic void add_utf8_token();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (r < 35) begin
			add_byte(8'($urandom_range(0, 127)));
		end else if (r < 55) begin
			add_byte(8'($urandom_range(8'h80, 8'hDF)));
			n = 1;
		end else if (r < 72) begin
			add_byte(8'($urandom_range(8'hE0, 8'hEF)));
			n = 2;
		end else if (r < 80) begin
			add_byte(8'($urandom_range(8'hF0, 8'hF7)));
			n = 3;
		end else if (r < 85) begin
			add_byte(8'($urandom_range(8'hF8, 8'hFB)));
			n = 4;
		end else if (r < 89) begin
			add_byte(8'($urandom_range(8'hFC, 8'hFD)));
			n = 5;
		end else if (r < 91) begin
			add_byte(8'($urandom_range(8'hFE, 8'hFF)));
		end else begin
			add_byte(8'($urandom_range(0, 255)));
		end
		repeat (n) add_byte(cont_byte());
	endfunction

	task automatic random_string(input logic [1:0] m);
		int n;
		int cut;
		if (m == MODE_UTF8) begin
			n = $urandom_range(1, 8);
			repeat (n) add_utf8_token();
			// sometimes cut the string inside a sequence
			if ($urandom_range(0, 99) < 15 && text_q.size() > 2) begin
				cut = $urandom_range(1, 2);
				repeat (cut) void'(text_q.pop_back());
			end
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			repeat (n) add_byte(8'($urandom_range(0, 255)));
		end
		send_text();
	endtask

	initial begin
		logic [1:0] phase_mode[8];
		int         phase_len[8];
		int         stop;
		sb = new();
		calm = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		is_last = 1'b0;
		cfg_valid = 1'b0;
		mode = MODE_UTF8;
		phase_mode = '{MODE_UTF8, MODE_U16_LE, MODE_U16_BE, MODE_UTF8,
			MODE_NONE, MODE_U16_BE, MODE_UTF8, MODE_U16_LE};
		phase_len = '{80, 70, 70, 80, 20, 70, 80, 70};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// utf-8 extremes, two and three byte sequences, long leads, cut-off, drop
		text_q = {8'h00, 8'h80, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
		send_text();
		text_q = {8'hF0, 8'h80, 8'h80, 8'h80, 8'hE2};
		send_text();
		text_q = {8'hFF, 8'h41};
		send_text();
		// utf-16 pairs and odd length
		write_mode(MODE_U16_LE);
		text_q = {8'h34, 8'h12, 8'h56};
		send_text();
		write_mode(MODE_U16_BE);
		text_q = {8'hFF};
		send_text();
		write_mode(MODE_NONE);
		text_q = {8'hAA};
		send_text();
		// mode changes inside one string keep the decoding state
		write_mode(MODE_U16_LE);
		send_byte(8'hC3, 1'b0);
		write_mode(MODE_UTF8);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		write_mode(MODE_U16_LE);
		send_byte(8'h00, 1'b0);
		write_mode(MODE_UTF8);
		send_byte(8'hFF, 1'b0);
		write_mode(MODE_U16_BE);
		send_byte(8'h12, 1'b1);

		for (int p = 0; p < 8; p++) begin
			write_mode(phase_mode[p]);
			calm = (p == 3);
			if (p == 0)
				hold_req = 1'b1;
			stop = bytes_sent + phase_len[p];
			while (bytes_sent < stop)
				random_string(phase_mode[p]);
		end
		calm = 1'b0;

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

[files.f]
rtl/core/uudec_pkg.sv
rtl/core/uudec_in_stage.sv
rtl/core/uudec_core.sv
rtl/core/uudec_out_stage.sv
rtl/core/utf8_utf16_to_ucs2_decoder.sv
test/testbench.sv
